### hw/rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// shared types and constants of the glob wildcard matcher
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_END     = 2'd3
    } op_t;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       advance;
        logic       rearm;
        logic [7:0] char_value;
    } cell_ctrl_t;

endpackage

### hw/rtl/gwm_item_if.sv
// ----------------------------------------------------------------------------
// gwm_item_if
// valid/ready channel carrying one op word of the matcher
// ----------------------------------------------------------------------------
interface gwm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] char_value;

    modport source (output valid, output op, output char_value, input ready);
    modport sink   (input valid, input op, input char_value, output ready);
endinterface

### hw/rtl/gwm_result_if.sv
// ----------------------------------------------------------------------------
// gwm_result_if
// valid/ready channel carrying one match result word
// ----------------------------------------------------------------------------
interface gwm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### hw/rtl/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// one pattern position: stored byte, loaded bit and active bit
// ----------------------------------------------------------------------------
module gwm_cell
    import gwm_pkg::*;
#(
    parameter logic ACT_INIT = 1'b0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       loaded_in,
    input  logic       step_in,
    input  logic       close_in,
    output logic       loaded,
    output logic       act,
    output logic       step_out,
    output logic       close_out
);

    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       loaded_reg;
    logic       loaded_next;
    logic       act_reg;
    logic       act_next;
    logic       write_here;
    logic       star_cur;
    logic       star_next;
    logic       hit;

    assign write_here  = ctrl.append & loaded_in & ~loaded_reg;
    assign char_next   = write_here ? ctrl.char_value : char_reg;
    assign loaded_next = ctrl.clear ? 1'b0 : (loaded_reg | write_here);

    assign star_cur  = loaded_reg & (char_reg == STAR_CHAR);
    assign star_next = loaded_next & (char_next == STAR_CHAR);
    assign hit       = (char_reg == ANY_CHAR) | (char_reg == ctrl.char_value);

    assign step_out = act_reg & loaded_reg & ~star_cur & hit;

    always_comb
    begin
        if (ctrl.rearm)
        begin
            act_next = close_in;
        end
        else if (ctrl.advance)
        begin
            act_next = (act_reg & star_cur) | step_in | close_in;
        end
        else
        begin
            act_next = act_reg;
        end
    end

    assign close_out = act_next & star_next;

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            act_reg    <= ACT_INIT;
        end
        else
        begin
            loaded_reg <= loaded_next;
            act_reg    <= act_next;
        end
    end

    assign loaded = loaded_reg;
    assign act    = act_reg;

endmodule

### hw/rtl/glob_wildcard_match_core.sv
// ----------------------------------------------------------------------------
// glob_wildcard_match_core
// streaming glob matcher built as a row of pattern cells
// ----------------------------------------------------------------------------
// The pattern sits in a row of MAX_PATTERN cells, one byte per cell, loaded by
// append words after a clear word; '*' matches any run, '?' any one byte.
// Words may follow back to back while item.ready holds: a subject byte
// updates all cells at once, with activity rippling forward through '*' cells
// inside the same cycle, so that ripple across the row sets the clock period.
// An end word returns one result word (matched, pattern_overflow) through an
// output register and rearms for the next subject; the item side stalls only
// while a result word waits on a sink that is not ready. Appends past the
// capacity set a sticky overflow flag that forces no match until the next
// clear. Pattern bytes start undefined and need no clearing pass after reset.
// ----------------------------------------------------------------------------
module glob_wildcard_match_core
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    gwm_item_if.sink     item,
    gwm_result_if.source result
);

    cell_ctrl_t           ctrl;
    op_t                  op;
    logic                 accept;
    logic                 end_word;

    logic [MAX_PATTERN:0]   loaded_link;
    logic [MAX_PATTERN:0]   step_link;
    logic [MAX_PATTERN:0]   close_link;
    logic [MAX_PATTERN-1:0] loaded_vec;
    logic [MAX_PATTERN-1:0] act_vec;

    logic act_end_reg;
    logic act_end_next;
    logic ovf_reg;
    logic ovf_next;
    logic tail_hit;

    logic res_valid_reg;
    logic res_valid_next;
    logic res_matched_reg;
    logic res_ovf_reg;

    assign op          = op_t'(item.op);
    assign item.ready  = ~res_valid_reg | result.ready;
    assign accept      = item.valid & item.ready;
    assign end_word    = accept & (op == OP_END);

    assign ctrl.clear      = accept & (op == OP_CLEAR);
    assign ctrl.append     = accept & (op == OP_APPEND);
    assign ctrl.advance    = accept & (op == OP_SUBJECT);
    assign ctrl.rearm      = accept & (op != OP_SUBJECT);
    assign ctrl.char_value = item.char_value;

    // neighbour links, position zero seeds the chain
    assign loaded_link[0] = 1'b1;
    assign step_link[0]   = 1'b0;
    assign close_link[0]  = ctrl.rearm;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        gwm_cell #(
            .ACT_INIT (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .loaded_in (loaded_link[i]),
            .step_in   (step_link[i]),
            .close_in  (close_link[i]),
            .loaded    (loaded_link[i+1]),
            .act       (act_vec[i]),
            .step_out  (step_link[i+1]),
            .close_out (close_link[i+1])
        );
    end

    assign loaded_vec = loaded_link[MAX_PATTERN:1];

    // end position past the last cell
    always_comb
    begin
        if (ctrl.rearm)
        begin
            act_end_next = close_link[MAX_PATTERN];
        end
        else if (ctrl.advance)
        begin
            act_end_next = step_link[MAX_PATTERN] | close_link[MAX_PATTERN];
        end
        else
        begin
            act_end_next = act_end_reg;
        end
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            ovf_next = 1'b0;
        end
        else if (ctrl.append & loaded_link[MAX_PATTERN])
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            ovf_next = ovf_reg;
        end
    end

    // only the position at the pattern end can be active beyond the loaded cells
    assign tail_hit = (|(act_vec & ~loaded_vec)) | act_end_reg;

    assign res_valid_next = end_word | (res_valid_reg & ~result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_end_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            act_end_reg   <= act_end_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_word)
        begin
            res_matched_reg <= tail_hit & ~ovf_reg;
            res_ovf_reg     <= ovf_reg;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.matched          = res_matched_reg;
    assign result.pattern_overflow = res_ovf_reg;

    // loaded cells form a contiguous run from position zero
    a_loaded_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((loaded_vec >> 1) & ~loaded_vec) == '0)
        else $error("loaded cells not contiguous");

    // no position beyond the pattern end is active
    a_no_act_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        ({act_end_reg, act_vec} & ~{loaded_vec, 1'b1}) == '0)
        else $error("active position past pattern end");

    // a rearm always leaves position zero active
    a_rearm_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rearm |=> act_vec[0])
        else $error("position zero inactive after rearm");

    // clear drops the overflow flag
    a_clear_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> !ovf_reg)
        else $error("overflow flag survived clear");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for glob_wildcard_match_core: op words are driven over
// the item channel with random idle bursts, each end word predicts one
// (matched, pattern_overflow) word from a local model of the active-position
// row, and every result word is checked in order against that prediction
// ----------------------------------------------------------------------------
module tb;
    import gwm_pkg::*;

    localparam int MAXP        = MAX_PATTERN_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int WORD_COUNT  = 650;
    localparam int CALM_FROM   = 560;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic clk;
    logic rst_n;

    gwm_item_if   item_ch ();
    gwm_result_if result_ch ();

    glob_wildcard_match_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // local copy of the matcher state
    logic [7:0]  pat_bytes [MAXP];
    int unsigned pat_len = 0;
    bit [MAXP:0] live    = 1;
    bit          ovf     = 1'b0;

    verdict_t verdict_q [$];
    int       mismatch_count = 0;
    int       words_sent     = 0;
    int       idle_cycles    = 0;
    bit       bursts_on      = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic void close_star_runs();
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i] && pat_bytes[i] == STAR_CHAR)
                live[i + 1] = 1'b1;
        end
    endfunction

    function automatic void rearm_subject();
        live    = '0;
        live[0] = 1'b1;
        close_star_runs();
    endfunction

    function automatic void step_subject(logic [7:0] c);
        bit [MAXP:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i])
            begin
                if (pat_bytes[i] == STAR_CHAR)
                    nxt[i] = 1'b1;
                else if (pat_bytes[i] == ANY_CHAR || pat_bytes[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        end
        live = nxt;
        close_star_runs();
    endfunction

    function automatic void predict_word(op_t op, logic [7:0] c);
        verdict_t v;
        case (op)
            OP_CLEAR:
            begin
                pat_len = 0;
                ovf     = 1'b0;
                rearm_subject();
            end
            OP_APPEND:
            begin
                if (pat_len < MAXP)
                begin
                    pat_bytes[pat_len] = c;
                    pat_len++;
                end
                else
                    ovf = 1'b1;
                rearm_subject();
            end
            OP_SUBJECT:
                step_subject(c);
            default:
            begin
                v.matched  = live[pat_len] && !ovf;
                v.overflow = ovf;
                verdict_q  = {verdict_q, v};
                rearm_subject();
            end
        endcase
    endfunction

    task automatic send_word(op_t op, logic [7:0] c);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.char_value <= c;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_word(op, c);
        words_sent++;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (verdict_q.size() != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'h61;
        if (r < 6)
            return 8'h62;
        if (r == 6)
            return STAR_CHAR;
        if (r == 7)
            return ANY_CHAR;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_end();
        send_word(OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_clear();
        send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
    endtask

    // builds a subject from the loaded pattern, sometimes with a corrupted byte
    task automatic send_fitting_subject();
        logic [7:0] pb [MAXP];
        int         n;
        bit         spoil;
        n     = pat_len;
        spoil = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
            pb[i] = pat_bytes[i];
        for (int i = 0; i < n; i++)
        begin
            if (pb[i] == STAR_CHAR)
            begin
                repeat ($urandom_range(0, 3)) send_word(OP_SUBJECT, pick_byte());
            end
            else if (spoil && $urandom_range(0, 3) == 0)
                send_word(OP_SUBJECT, 8'($urandom_range(0, 255)));
            else if (pb[i] == ANY_CHAR)
                send_word(OP_SUBJECT, 8'($urandom_range(0, 255)));
            else
                send_word(OP_SUBJECT, pb[i]);
        end
        if (spoil && $urandom_range(0, 1) == 0)
            send_word(OP_SUBJECT, pick_byte());
        send_end();
    endtask

    task automatic test_empty_pattern();
        send_end();
        send_clear();
        send_end();
        send_word(OP_SUBJECT, 8'h61);
        send_end();
    endtask

    task automatic test_wildcards();
        send_clear();
        send_word(OP_APPEND, STAR_CHAR);
        send_word(OP_APPEND, ANY_CHAR);
        send_word(OP_APPEND, 8'h00);
        send_word(OP_APPEND, 8'hFF);
        send_word(OP_SUBJECT, 8'h78);
        send_word(OP_SUBJECT, 8'h00);
        send_word(OP_SUBJECT, 8'h00);
        send_word(OP_SUBJECT, 8'hFF);
        send_end();
        send_word(OP_SUBJECT, 8'h00);
        send_word(OP_SUBJECT, 8'hFF);
        send_end();
    endtask

    task automatic test_append_mid_subject();
        send_clear();
        send_word(OP_APPEND, 8'h61);
        send_word(OP_SUBJECT, 8'h61);
        send_word(OP_APPEND, 8'h62);
        send_word(OP_SUBJECT, 8'h61);
        send_word(OP_SUBJECT, 8'h62);
        send_end();
    endtask

    task automatic test_overflow();
        send_clear();
        repeat (MAXP - 1) send_word(OP_APPEND, STAR_CHAR);
        send_word(OP_APPEND, 8'h61);
        send_word(OP_SUBJECT, 8'h61);
        send_end();
        send_word(OP_APPEND, 8'h7A);
        send_word(OP_SUBJECT, 8'h61);
        send_end();
        send_clear();
        send_end();
    endtask

    task automatic test_random_traffic();
        int plen;
        int next_drain;
        next_drain = words_sent + 120;
        while (words_sent < WORD_COUNT)
        begin
            if (words_sent >= CALM_FROM)
                bursts_on = 1'b0;
            if (words_sent >= next_drain)
            begin
                drain_results();
                next_drain = words_sent + 120;
            end
            if ($urandom_range(0, 9) < 8)
                send_clear();
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 8);
            repeat (plen) send_word(OP_APPEND, pick_byte());
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0)
                    send_fitting_subject();
                else
                begin
                    repeat ($urandom_range(0, 8)) send_word(OP_SUBJECT, pick_byte());
                    send_end();
                end
            end
        end
    endtask

    // result side stalls
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            if (bursts_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got matched %0b overflow %0b",
                         $time, result_ch.matched, result_ch.pattern_overflow);
                mismatch_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (result_ch.matched !== want.matched)
                begin
                    $display("%0t: matched expected %0b got %0b",
                             $time, want.matched, result_ch.matched);
                    mismatch_count++;
                end
                if (result_ch.pattern_overflow !== want.overflow)
                begin
                    $display("%0t: pattern_overflow expected %0b got %0b",
                             $time, want.overflow, result_ch.pattern_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.op         <= OP_CLEAR;
        item_ch.char_value <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_wildcards();
        test_append_mid_subject();
        test_overflow();
        drain_results();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
